// File: hw/rtl/ise_pkg.sv
// Shared constants and codes for the indexed stack engine.
package ise_pkg;

	localparam int DEPTH   = 16;
	localparam int MAX_OUT = 16;
	localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW      = $clog2(DEPTH + 1);
	localparam int DIDX_W  = 5;
	localparam int CMPW    = (CW > DIDX_W) ? CW : DIDX_W;
	localparam int DUMP_MAX = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;

	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [FUNC_W-1:0] FUNC_PUSH    = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEP    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_REPLACE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_DUMP    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

endpackage

// File: hw/rtl/indexed_stack_engine_unit.sv
// Indexed stack engine: bounded LIFO of signed words with peek, replace and dump.
//
// Each input word carries an operation in s_axis_tuser (push, pop, peep, replace,
// dump) with a value and a depth in s_axis_tdata. Entries live in one synchronous
// single-port-style memory with a registered read. Push, replace and every error
// need no read and load their result into the output register on acceptance; pop
// and peep read the memory, then pass the word to the output register; a dump
// reads up from slot 0, one result word per cycle while the output is not stalled.
// One item is worked on at a time; the next item is taken once the previous one
// has handed its last result to the output register. Status in m_axis_tuser: 0 ok,
// 1 overflow, 2 underflow, bad depth or undefined func, 3 empty dump. No clearing
// pass after reset: only entries below the fill count are ever read.
module indexed_stack_engine_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] value, [36:32] depth_index, [39:37] zero
	input  logic [ise_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [2:0] func
	input  logic [ise_pkg::FUNC_W-1:0]         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [31:0] data, [35:32] position, [39:36] zero
	output logic [ise_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// [1:0] status
	output logic [ise_pkg::STATUS_W-1:0]       m_axis_tuser,
	output logic                               m_axis_tlast
);
	import ise_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DUMP
	} state_t;

	state_t              state_q, state_d;
	logic [CW-1:0]       fill_q, fill_d;
	logic [AW-1:0]       idx_q, idx_d;
	logic                pop_q, pop_d;

	logic [DATA_W-1:0]   stack_mem_q [DEPTH];
	logic [DATA_W-1:0]   rd_data_q;

	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;

	logic                acc;
	logic                out_free;
	logic [FUNC_W-1:0]   in_func;
	logic [VALUE_W-1:0]  in_value;
	logic [DIDX_W-1:0]   in_depth;
	logic                full, empty, depth_ok, dump_last;
	logic [CMPW-1:0]     depth_ext, fill_ext;
	logic [AW-1:0]       peek_slot, top_slot;
	logic [CW-1:0]       dump_n;

	logic                ld;
	logic [DATA_W-1:0]   ld_data;
	logic [POS_W-1:0]    ld_pos;
	logic [STATUS_W-1:0] ld_status;
	logic                ld_last;
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [DATA_W-1:0]   wr_data;

	assign in_value = s_axis_tdata[VALUE_W-1:0];
	assign in_depth = s_axis_tdata[VALUE_W +: DIDX_W];
	assign in_func  = s_axis_tuser;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;

	assign full      = (fill_q == CW'(DEPTH));
	assign empty     = (fill_q == '0);
	assign depth_ext = CMPW'(in_depth);
	assign fill_ext  = CMPW'(fill_q);
	assign depth_ok  = (depth_ext != '0) && (depth_ext <= fill_ext);
	assign peek_slot = AW'(fill_ext - depth_ext);
	assign top_slot  = AW'(fill_q - CW'(1));
	assign dump_n    = (fill_q > CW'(DUMP_MAX)) ? CW'(DUMP_MAX) : fill_q;
	assign dump_last = (CW'(idx_q) + CW'(1)) == dump_n;

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		pop_d     = pop_q;
		ld        = 1'b0;
		ld_data   = '0;
		ld_pos    = '0;
		ld_status = ST_OK;
		ld_last   = 1'b1;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_data   = '0;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (in_func)
						FUNC_PUSH: begin
							ld = 1'b1;
							if (full) begin
								ld_status = ST_OVER;
							end else begin
								wr_en   = 1'b1;
								wr_addr = AW'(fill_q);
								wr_data = in_value;
								fill_d  = fill_q + CW'(1);
								ld_pos  = POS_W'(AW'(fill_q));
							end
						end
						FUNC_POP: begin
							if (empty) begin
								ld        = 1'b1;
								ld_status = ST_UNDER;
							end else begin
								rd_en   = 1'b1;
								rd_addr = top_slot;
								idx_d   = top_slot;
								pop_d   = 1'b1;
								fill_d  = fill_q - CW'(1);
								state_d = S_READ;
							end
						end
						FUNC_PEEP: begin
							if (!depth_ok) begin
								ld        = 1'b1;
								ld_status = ST_UNDER;
							end else begin
								rd_en   = 1'b1;
								rd_addr = peek_slot;
								idx_d   = peek_slot;
								pop_d   = 1'b0;
								state_d = S_READ;
							end
						end
						FUNC_REPLACE: begin
							ld = 1'b1;
							if (!depth_ok) begin
								ld_status = ST_UNDER;
							end else begin
								wr_en   = 1'b1;
								wr_addr = peek_slot;
								wr_data = in_value;
								ld_pos  = POS_W'(peek_slot);
							end
						end
						FUNC_DUMP: begin
							if (empty) begin
								ld        = 1'b1;
								ld_status = ST_EMPTY;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = S_DUMP;
							end
						end
						default: begin
							ld        = 1'b1;
							ld_status = ST_UNDER;
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_data = rd_data_q;
					ld_pos  = POS_W'(idx_q);
					// freed slot goes back to zero
					wr_en   = pop_q;
					wr_addr = idx_q;
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (out_free) begin
					ld      = 1'b1;
					ld_data = rd_data_q;
					ld_pos  = POS_W'(idx_q);
					ld_last = dump_last;
					if (dump_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// rd_data_q only moves on a read, so a stalled result word holds
	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= stack_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			idx_q        <= '0;
			pop_q        <= 1'b0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_pos_q    <= '0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
			pop_q   <= pop_d;
			if (ld) begin
				out_valid_q  <= 1'b1;
				out_data_q   <= ld_data;
				out_pos_q    <= ld_pos;
				out_status_q <= ld_status;
				out_last_q   <= ld_last;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - DATA_W - POS_W)'(0), out_pos_q, out_data_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// File: verif/stack_result_checker.sv
// Checker for the indexed stack engine: tracks the stack, predicts result words, compares.
`timescale 1ns / 1ps

module stack_result_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	// [31:0] value, [36:32] depth_index, [39:37] zero
	input  logic [ise_pkg::IN_TDATA_W-1:0]     s_tdata,
	// [2:0] func
	input  logic [ise_pkg::FUNC_W-1:0]         s_tuser,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	// [31:0] data, [35:32] position, [39:36] zero
	input  logic [ise_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// [1:0] status
	input  logic [ise_pkg::STATUS_W-1:0]       m_tuser,
	input  logic                               m_tlast,
	output int                                 mismatches,
	output int                                 awaited
);
	import ise_pkg::*;

	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [POS_W-1:0]    pos;
		logic [STATUS_W-1:0] status;
		logic                last;
	} stack_result_t;

	logic [DATA_W-1:0] slots [DEPTH];
	int                fill;
	stack_result_t     pending_results [$];

	function automatic void queue_result(input logic [DATA_W-1:0] d, input int slot,
			input logic [STATUS_W-1:0] st, input logic lst);
		stack_result_t r;
		r.data   = d;
		r.pos    = POS_W'(slot);
		r.status = st;
		r.last   = lst;
		pending_results.push_back(r);
	endfunction

	// Updates the stack copy and queues the result words the operation causes.
	function automatic void stack_apply_op(input logic [FUNC_W-1:0] op,
			input logic [VALUE_W-1:0] val, input logic [DIDX_W-1:0] dep);
		int slot;
		int n;
		case (op)
			FUNC_PUSH: begin
				if (fill >= DEPTH) begin
					queue_result('0, 0, ST_OVER, 1'b1);
				end else begin
					slots[fill] = val;
					queue_result('0, fill, ST_OK, 1'b1);
					fill++;
				end
			end
			FUNC_POP: begin
				if (fill == 0) begin
					queue_result('0, 0, ST_UNDER, 1'b1);
				end else begin
					slot = fill - 1;
					queue_result(slots[slot], slot, ST_OK, 1'b1);
					slots[slot] = '0;
					fill = slot;
				end
			end
			FUNC_PEEP, FUNC_REPLACE: begin
				if (dep < 1 || int'(dep) > fill) begin
					queue_result('0, 0, ST_UNDER, 1'b1);
				end else begin
					slot = fill - int'(dep);
					if (op == FUNC_PEEP) begin
						queue_result(slots[slot], slot, ST_OK, 1'b1);
					end else begin
						slots[slot] = val;
						queue_result('0, slot, ST_OK, 1'b1);
					end
				end
			end
			FUNC_DUMP: begin
				if (fill == 0) begin
					queue_result('0, 0, ST_EMPTY, 1'b1);
				end else begin
					n = (fill > MAX_OUT) ? MAX_OUT : fill;
					for (int i = 0; i < n; i++)
						queue_result(slots[i], i, ST_OK, i + 1 == n);
				end
			end
			default: queue_result('0, 0, ST_UNDER, 1'b1);
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		$display("mismatch: %s got %0h want %0h", what, got, want);
	endtask

	always @(posedge clk) begin
		stack_result_t want;
		if (!arst_n) begin
			mismatches = 0;
			fill       = 0;
			for (int i = 0; i < DEPTH; i++)
				slots[i] = '0;
			pending_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				stack_apply_op(s_tuser, s_tdata[31:0], s_tdata[36:32]);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected word, data", m_tdata[31:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[31:0] !== want.data)
						report_mismatch("data", m_tdata[31:0], want.data);
					if (m_tdata[35:32] !== want.pos)
						report_mismatch("position", DATA_W'(m_tdata[35:32]),
							DATA_W'(want.pos));
					if (m_tuser !== want.status)
						report_mismatch("status", DATA_W'(m_tuser), DATA_W'(want.status));
					if (m_tlast !== want.last)
						report_mismatch("last", DATA_W'(m_tlast), DATA_W'(want.last));
				end
			end
		end
		awaited = pending_results.size();
	end

endmodule

// File: verif/indexed_stack_engine_unit_test.sv
// Testbench top for the indexed stack engine: clock, reset, stimulus, receiver pacing, verdict.
`timescale 1ns / 1ps

module indexed_stack_engine_unit_test;
	import ise_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 90;
	localparam int TAIL_CYCLES = 24;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [FUNC_W-1:0]      s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]    m_axis_tuser;
	logic                   m_axis_tlast;

	int   mismatches;
	int   awaited;
	int   cycle_cnt = 0;
	int   burst_left = 0;
	logic no_gaps = 1'b0;
	logic hold_req = 1'b0;

	indexed_stack_engine_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	stack_result_checker result_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.m_tlast    (m_axis_tlast),
		.mismatches (mismatches),
		.awaited    (awaited)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Offer one word, hold it until taken, then maybe open a gap.
	task automatic send_word(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] val,
			input logic [DIDX_W-1:0] dep);
		s_axis_tuser  = op;
		s_axis_tdata  = {3'b000, dep, val};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		@(negedge clk);
		if (!no_gaps) begin
			if (burst_left == 0) begin
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				burst_left = $urandom_range(1, 10);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (awaited != 0)
			@(negedge clk);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Weighted random operation; the remainder after push and pop is spread
	// over peep, replace, dump and the undefined codes.
	task automatic send_random(input int push_w, input int pop_w);
		int r;
		int k;
		logic [FUNC_W-1:0] op;
		logic [DIDX_W-1:0] dep;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		if (r < push_w)
			op = FUNC_PUSH;
		else if (r < push_w + pop_w)
			op = FUNC_POP;
		else if (k < 35)
			op = FUNC_PEEP;
		else if (k < 70)
			op = FUNC_REPLACE;
		else if (k < 90)
			op = FUNC_DUMP;
		else
			op = FUNC_W'($urandom_range(5, 7));
		if ($urandom_range(0, 9) == 0)
			dep = DIDX_W'($urandom_range(0, 31));
		else
			dep = DIDX_W'($urandom_range(1, 16));
		send_word(op, pick_value(), dep);
	endtask

	// Receiver: switches among four random stall patterns; one long hold-off on request.
	initial begin
		int rx_mode;
		int rx_cnt;
		logic hold_done;
		rx_mode   = 0;
		rx_cnt    = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end
			if (rx_cnt % 50 == 0)
				rx_mode = $urandom_range(0, 3);
			case (rx_mode)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = $urandom_range(0, 1);
				2: m_axis_tready = (rx_cnt % 4 == 0);
				default: m_axis_tready = ($urandom_range(0, 9) != 0);
			endcase
			rx_cnt++;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// empty stack and undefined operation codes
		send_word(FUNC_DUMP, 32'h0, 5'd0);
		send_word(FUNC_POP, 32'h0, 5'd0);
		send_word(FUNC_PEEP, 32'h0, 5'd1);
		send_word(FUNC_REPLACE, 32'h1234_5678, 5'd0);
		send_word(3'd5, 32'hFFFF_FFFF, 5'd31);
		send_word(3'd6, 32'h0, 5'd1);
		send_word(3'd7, 32'h8000_0000, 5'd16);
		// value extremes, then peep and replace inside and outside the fill
		send_word(FUNC_PUSH, 32'h7FFF_FFFF, 5'd0);
		send_word(FUNC_PUSH, 32'h8000_0000, 5'd31);
		send_word(FUNC_PUSH, 32'hFFFF_FFFF, 5'd0);
		send_word(FUNC_PUSH, 32'h0000_0000, 5'd0);
		send_word(FUNC_PEEP, 32'h0, 5'd1);
		send_word(FUNC_PEEP, 32'h0, 5'd4);
		send_word(FUNC_PEEP, 32'h0, 5'd5);
		send_word(FUNC_PEEP, 32'h0, 5'd0);
		send_word(FUNC_REPLACE, 32'h5A5A_5A5A, 5'd2);
		send_word(FUNC_REPLACE, 32'hA5A5_A5A5, 5'd31);
		send_word(FUNC_DUMP, 32'h0, 5'd0);
		send_word(FUNC_POP, 32'h0, 5'd0);
		send_word(FUNC_PEEP, 32'h0, 5'd31);

		// fill past the top: overflow, then a full dump
		for (int i = 0; i < 20; i++)
			send_word(FUNC_PUSH, pick_value(), DIDX_W'($urandom_range(0, 31)));
		send_word(FUNC_DUMP, 32'h0, 5'd0);
		send_word(FUNC_PUSH, 32'h1, 5'd0);
		send_word(FUNC_PEEP, 32'h0, 5'd16);
		send_word(FUNC_REPLACE, 32'hDEAD_0001, 5'd16);

		// alternate draining and filling phases to sweep the fill level
		for (int ph = 0; ph < 5; ph++) begin
			no_gaps = (ph == 2);
			for (int i = 0; i < 36; i++) begin
				if (ph == 1 && i == 10) begin
					hold_req = 1'b1;
					no_gaps  = 1'b1;
				end
				if (ph == 1 && i == 24)
					no_gaps = 1'b0;
				if (ph % 2 == 0)
					send_random(15, 55);
				else
					send_random(55, 15);
			end
			if (ph == 2)
				wait_drained();
		end

		no_gaps = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && awaited == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: indexed_stack_engine_unit.f
hw/rtl/ise_pkg.sv
hw/rtl/indexed_stack_engine_unit.sv
verif/stack_result_checker.sv
verif/indexed_stack_engine_unit_test.sv
